/* rtl/sdt_pkg.sv */
package sdt_pkg;

	localparam int COORD_W   = 16;
	localparam int BASE_W    = 24;
	localparam int CFG_W     = 24;
	localparam int IDX_W     = 3;
	localparam int DIV_W     = 16;
	localparam int PROD_W    = COORD_W + BASE_W;
	localparam int DVD_W     = PROD_W + 1;
	localparam int ACC_W     = DIV_W + DVD_W;
	localparam int OUT_W     = 32;
	localparam int NUM_LANES = 3;

	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_Z = 2;

	localparam logic [IDX_W-1:0] REG_FOCAL    = 3'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd2;
	localparam logic [IDX_W-1:0] REG_BASELINE = 3'd3;
	localparam logic [IDX_W-1:0] REG_MIN_DISP = 3'd4;
	localparam logic [IDX_W-1:0] REG_VERTICAL = 3'd5;

	typedef struct packed {
		logic [COORD_W-1:0] focal_length;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [BASE_W-1:0]  stereo_baseline;
		logic [COORD_W-1:0] min_disparity;
		logic               vertical_axis;
	} cfg_t;

	// acc per lane: {remainder, dividend bits still to shift / quotient bits shifted in}
	typedef struct packed {
		logic [NUM_LANES-1:0][ACC_W-1:0] acc;
		logic [NUM_LANES-1:0]            neg;
		logic [DIV_W-1:0]                div;
		logic                            ok;
	} work_t;

	typedef struct packed {
		logic [OUT_W-1:0] point_x;
		logic [OUT_W-1:0] point_y;
		logic [OUT_W-1:0] point_z;
		logic             point_valid;
	} result_t;

endpackage

/* rtl/sdt_front.sv */
module sdt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_take,
	input  logic [sdt_pkg::COORD_W-1:0]   left_x,
	input  logic [sdt_pkg::COORD_W-1:0]   left_y,
	input  logic [sdt_pkg::COORD_W-1:0]   right_x,
	input  logic [sdt_pkg::COORD_W-1:0]   right_y,
	input  sdt_pkg::cfg_t                 cfg,
	output logic                          v_s3,
	output sdt_pkg::work_t                work_s3
);

	logic signed [sdt_pkg::COORD_W:0] disp;
	logic signed [sdt_pkg::COORD_W:0] nx;
	logic signed [sdt_pkg::COORD_W:0] ny;
	logic        [sdt_pkg::COORD_W:0] nx_neg;
	logic        [sdt_pkg::COORD_W:0] ny_neg;

	logic                                                v_s1;
	logic                                                ok_s1;
	logic [sdt_pkg::DIV_W-1:0]                           div_s1;
	logic [sdt_pkg::NUM_LANES-1:0]                       neg_s1;
	logic [sdt_pkg::NUM_LANES-1:0][sdt_pkg::COORD_W-1:0] mag_s1;

	logic                                                v_s2;
	logic                                                ok_s2;
	logic [sdt_pkg::DIV_W-1:0]                           div_s2;
	logic [sdt_pkg::NUM_LANES-1:0]                       neg_s2;
	logic [sdt_pkg::NUM_LANES-1:0][sdt_pkg::PROD_W-1:0]  prod_s2;

	always_comb begin
		if (cfg.vertical_axis) begin
			disp = $signed({1'b0, left_y}) - $signed({1'b0, right_y});
		end else begin
			disp = $signed({1'b0, left_x}) - $signed({1'b0, right_x});
		end
		nx     = $signed({1'b0, left_x}) - $signed({1'b0, cfg.center_x});
		ny     = $signed({1'b0, left_y}) - $signed({1'b0, cfg.center_y});
		nx_neg = -nx;
		ny_neg = -ny;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: disparity test and numerator magnitudes
			ok_s1  <= disp > $signed({1'b0, cfg.min_disparity});
			div_s1 <= disp[sdt_pkg::DIV_W-1:0];
			neg_s1[sdt_pkg::LANE_X] <= nx[sdt_pkg::COORD_W];
			neg_s1[sdt_pkg::LANE_Y] <= ny[sdt_pkg::COORD_W];
			neg_s1[sdt_pkg::LANE_Z] <= 1'b0;
			mag_s1[sdt_pkg::LANE_X] <= nx[sdt_pkg::COORD_W] ?
				nx_neg[sdt_pkg::COORD_W-1:0] : nx[sdt_pkg::COORD_W-1:0];
			mag_s1[sdt_pkg::LANE_Y] <= ny[sdt_pkg::COORD_W] ?
				ny_neg[sdt_pkg::COORD_W-1:0] : ny[sdt_pkg::COORD_W-1:0];
			mag_s1[sdt_pkg::LANE_Z] <= cfg.focal_length;

			// stage 2: scale by baseline
			ok_s2  <= ok_s1;
			div_s2 <= div_s1;
			neg_s2 <= neg_s1;
			for (int i = 0; i < sdt_pkg::NUM_LANES; i++) begin
				prod_s2[i] <= sdt_pkg::PROD_W'(mag_s1[i]) *
					sdt_pkg::PROD_W'(cfg.stereo_baseline);
			end

			// stage 3: add half divisor for round-to-nearest
			work_s3.ok  <= ok_s2;
			work_s3.div <= div_s2;
			work_s3.neg <= neg_s2;
			for (int i = 0; i < sdt_pkg::NUM_LANES; i++) begin
				work_s3.acc[i] <= sdt_pkg::ACC_W'(sdt_pkg::DVD_W'(prod_s2[i]) +
					sdt_pkg::DVD_W'(div_s2[sdt_pkg::DIV_W-1:1]));
			end
		end
	end

endmodule

/* rtl/sdt_div_cell.sv */
module sdt_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  sdt_pkg::work_t work_in,
	output logic           v_s1,
	output sdt_pkg::work_t work_s1
);

	// one restoring-division step per lane: shift in next dividend bit, trial subtract
	sdt_pkg::work_t                              work_nxt;
	logic [sdt_pkg::NUM_LANES-1:0][sdt_pkg::DIV_W:0] trial;
	logic [sdt_pkg::NUM_LANES-1:0]               ge;

	always_comb begin
		work_nxt = work_in;
		for (int i = 0; i < sdt_pkg::NUM_LANES; i++) begin
			trial[i] = work_in.acc[i][sdt_pkg::ACC_W-1 -: (sdt_pkg::DIV_W + 1)];
			ge[i]    = trial[i] >= {1'b0, work_in.div};
			work_nxt.acc[i][sdt_pkg::ACC_W-1 -: sdt_pkg::DIV_W] = ge[i] ?
				sdt_pkg::DIV_W'(trial[i] - {1'b0, work_in.div}) :
				trial[i][sdt_pkg::DIV_W-1:0];
			work_nxt.acc[i][sdt_pkg::DVD_W-1:0] =
				{work_in.acc[i][sdt_pkg::DVD_W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work_nxt;
		end
	end

endmodule

/* rtl/stereo_disparity_triangulate_unit.sv */
// Stereo triangulation: one matched keypoint pair in, one Q16.16 camera-frame point out,
// X/Y/Z = N * baseline / disparity, rounded to nearest (ties away from zero) and saturated.
// Throughput is one item per clock while the skid entry is empty. An item passes
// through three front stages (disparity, 16x24 multiply, rounding bias), a chain of 41
// divide cells, one quotient bit per cell for all three coordinates, then the output
// register. Behind the output register sits one skid entry; when it is occupied the
// whole chain holds and in_ready drops, so in_ready depends on registers only.
// Configuration registers: 0 focal_length, 1 center_x, 2 center_y, 3 stereo_baseline,
// 4 min_disparity, 5 vertical_axis; other indexes are ignored. Write them only while idle.
module stereo_disparity_triangulate_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sdt_pkg::IDX_W-1:0]     cfg_index,
	input  logic [sdt_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sdt_pkg::COORD_W-1:0]   left_x,
	input  logic [sdt_pkg::COORD_W-1:0]   left_y,
	input  logic [sdt_pkg::COORD_W-1:0]   right_x,
	input  logic [sdt_pkg::COORD_W-1:0]   right_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [sdt_pkg::OUT_W-1:0] point_x,
	output logic signed [sdt_pkg::OUT_W-1:0] point_y,
	output logic signed [sdt_pkg::OUT_W-1:0] point_z,
	output logic                          point_valid
);

	sdt_pkg::cfg_t   cfg_q;
	logic            en;
	logic            chain_v    [sdt_pkg::DVD_W+1];
	sdt_pkg::work_t  chain_work [sdt_pkg::DVD_W+1];

	logic                                                 out_v_q;
	logic                                                 skid_v_q;
	sdt_pkg::result_t                                     out_q;
	sdt_pkg::result_t                                     skid_q;
	sdt_pkg::result_t                                     fin;
	logic [sdt_pkg::NUM_LANES-1:0][sdt_pkg::OUT_W-1:0]    lane_val;
	logic [sdt_pkg::DVD_W-1:0]                            quo;
	logic                                                 big;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_length    <= 16'd16;
			cfg_q.center_x        <= 16'd8;
			cfg_q.center_y        <= 16'd8;
			cfg_q.stereo_baseline <= 24'd65536;
			cfg_q.min_disparity   <= 16'd0;
			cfg_q.vertical_axis   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdt_pkg::REG_FOCAL:    cfg_q.focal_length    <= cfg_data[sdt_pkg::COORD_W-1:0];
				sdt_pkg::REG_CENTER_X: cfg_q.center_x        <= cfg_data[sdt_pkg::COORD_W-1:0];
				sdt_pkg::REG_CENTER_Y: cfg_q.center_y        <= cfg_data[sdt_pkg::COORD_W-1:0];
				sdt_pkg::REG_BASELINE: cfg_q.stereo_baseline <= cfg_data[sdt_pkg::BASE_W-1:0];
				sdt_pkg::REG_MIN_DISP: cfg_q.min_disparity   <= cfg_data[sdt_pkg::COORD_W-1:0];
				sdt_pkg::REG_VERTICAL: cfg_q.vertical_axis   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en       = !skid_v_q;
	assign in_ready = en;

	sdt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_take (in_valid && en),
		.left_x  (left_x),
		.left_y  (left_y),
		.right_x (right_x),
		.right_y (right_y),
		.cfg     (cfg_q),
		.v_s3    (chain_v[0]),
		.work_s3 (chain_work[0])
	);

	for (genvar g = 0; g < sdt_pkg::DVD_W; g++) begin : g_cell
		sdt_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (chain_v[g]),
			.work_in (chain_work[g]),
			.v_s1    (chain_v[g+1]),
			.work_s1 (chain_work[g+1])
		);
	end

	// sign restore and saturation to signed 32 bits; zero when the disparity test fails
	always_comb begin
		quo = '0;
		big = 1'b0;
		for (int i = 0; i < sdt_pkg::NUM_LANES; i++) begin
			quo = chain_work[sdt_pkg::DVD_W].acc[i][sdt_pkg::DVD_W-1:0];
			big = |quo[sdt_pkg::DVD_W-1:sdt_pkg::OUT_W-1];
			if (!chain_work[sdt_pkg::DVD_W].ok) begin
				lane_val[i] = '0;
			end else if (chain_work[sdt_pkg::DVD_W].neg[i]) begin
				lane_val[i] = big ? {1'b1, {(sdt_pkg::OUT_W-1){1'b0}}} :
					-quo[sdt_pkg::OUT_W-1:0];
			end else begin
				lane_val[i] = big ? {1'b0, {(sdt_pkg::OUT_W-1){1'b1}}} :
					quo[sdt_pkg::OUT_W-1:0];
			end
		end
		fin.point_x     = lane_val[sdt_pkg::LANE_X];
		fin.point_y     = lane_val[sdt_pkg::LANE_Y];
		fin.point_z     = lane_val[sdt_pkg::LANE_Z];
		fin.point_valid = chain_work[sdt_pkg::DVD_W].ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (out_v_q && !out_ready) begin
				skid_v_q <= chain_v[sdt_pkg::DVD_W];
			end else begin
				out_v_q <= chain_v[sdt_pkg::DVD_W];
			end
		end else if (out_ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_v_q && !out_ready) begin
				skid_q <= fin;
			end else begin
				out_q <= fin;
			end
		end else if (out_ready) begin
			out_q <= skid_q;
		end
	end

	assign out_valid   = out_v_q;
	assign point_x     = out_q.point_x;
	assign point_y     = out_q.point_y;
	assign point_z     = out_q.point_z;
	assign point_valid = out_q.point_valid;

endmodule
